### hdl/mpjq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpjq_pkg
// Shared types, sizes and codes for the max-priority job queue.
// ----------------------------------------------------------------------------
package mpjq_pkg;

  localparam int DEPTH  = 8;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMD_W  = 2;
  localparam int ID_W   = 16;
  localparam int PRI_W  = 8;
  localparam int BURST_W = 16;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 4;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRI_W-1:0]   pri;
    logic [BURST_W-1:0] burst;
  } job_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    job_t             wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

endpackage

### hdl/mpjq_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpjq_store
// Job storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mpjq_store (
  input  logic              clk,
  input  mpjq_pkg::mem_req_t req,
  output mpjq_pkg::job_t     rd_data
);
  import mpjq_pkg::*;

  job_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

### hdl/mpjq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpjq_ctrl
// Command sequencer: append, priority scan and shift-down, list-out.
// ----------------------------------------------------------------------------
module mpjq_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mpjq_pkg::CMD_W-1:0]    in_command,
  input  logic [mpjq_pkg::ID_W-1:0]     in_job_id,
  input  logic [mpjq_pkg::PRI_W-1:0]    in_job_priority,
  input  logic [mpjq_pkg::BURST_W-1:0]  in_job_burst,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mpjq_pkg::STAT_W-1:0]   out_status,
  output logic [mpjq_pkg::ID_W-1:0]     out_id,
  output logic [mpjq_pkg::PRI_W-1:0]    out_priority,
  output logic [mpjq_pkg::BURST_W-1:0]  out_burst,
  output logic [mpjq_pkg::OCC_W-1:0]    out_occupancy,
  output logic                          out_last_item,
  output mpjq_pkg::mem_req_t            mem_req,
  input  mpjq_pkg::job_t                mem_rd_data
);
  import mpjq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_LIST,
    S_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  job_t              res_entry_r, res_entry_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  job_t              out_entry_r, out_entry_nxt;
  logic [OCC_W-1:0]  out_occ_r, out_occ_nxt;
  logic              out_last_r, out_last_nxt;

  logic              slot_free;
  logic              take;
  logic [IDX_W-1:0]  cand_pos;
  logic              ptr_last;
  job_t              in_entry;

  assign in_ready  = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign take      = (ptr_r == '0) || (mem_rd_data.pri > res_entry_r.pri);
  assign cand_pos  = take ? ptr_r : pos_r;
  assign ptr_last  = (CNT_W'(ptr_r) + CNT_W'(1)) == cnt_r;
  assign in_entry  = '{id: in_job_id, pri: in_job_priority, burst: in_job_burst};

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ptr_nxt        = ptr_r;
    pos_nxt        = pos_r;
    res_entry_nxt  = res_entry_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_occ_nxt    = out_occ_r;
    out_last_nxt   = out_last_r;
    mem_req        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_entry_nxt  = '0;
          res_status_nxt = STAT_OK;
          ptr_nxt        = '0;
          pos_nxt        = '0;
          state_nxt      = S_OUT;
          priority case (in_command)
            CMD_INSERT: begin
              if (cnt_r == CNT_W'(DEPTH)) begin
                res_status_nxt = STAT_OVERFLOW;
              end else begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = IDX_W'(cnt_r);
                mem_req.wr_data = in_entry;
                cnt_nxt         = cnt_r + CNT_W'(1);
              end
            end
            CMD_REMOVE, CMD_LIST: begin
              if (cnt_r == '0) begin
                res_status_nxt = STAT_EMPTY;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
                state_nxt       = (in_command == CMD_REMOVE) ? S_SCAN : S_LIST;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (take) begin
          res_entry_nxt = mem_rd_data;
          pos_nxt       = ptr_r;
        end
        if (!ptr_last) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ptr_r + IDX_W'(1);
          ptr_nxt         = ptr_r + IDX_W'(1);
        end else if ((CNT_W'(cand_pos) + CNT_W'(1)) < cnt_r) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = cand_pos + IDX_W'(1);
          ptr_nxt         = cand_pos;
          state_nxt       = S_SHIFT;
        end else begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_OUT;
        end
      end

      S_SHIFT: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = ptr_r;
        mem_req.wr_data = mem_rd_data;
        if ((CNT_W'(ptr_r) + CNT_W'(2)) < cnt_r) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ptr_r + IDX_W'(2);
          ptr_nxt         = ptr_r + IDX_W'(1);
        end else begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_OUT;
        end
      end

      S_LIST: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_entry_nxt  = mem_rd_data;
          out_occ_nxt    = OCC_W'(cnt_r);
          out_last_nxt   = ptr_last;
          if (ptr_last) begin
            state_nxt = S_IDLE;
          end else begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = ptr_r + IDX_W'(1);
            ptr_nxt         = ptr_r + IDX_W'(1);
          end
        end
      end

      S_OUT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_entry_nxt  = res_entry_r;
          out_occ_nxt    = OCC_W'(cnt_nxt);
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r        <= ptr_nxt;
    pos_r        <= pos_nxt;
    res_entry_r  <= res_entry_nxt;
    res_status_r <= res_status_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_occ_r    <= out_occ_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_id        = out_entry_r.id;
  assign out_priority  = out_entry_r.pri;
  assign out_burst     = out_entry_r.burst;
  assign out_occupancy = out_occ_r;
  assign out_last_item = out_last_r;

endmodule

### hdl/max_priority_job_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_priority_job_queue
// Bounded job queue in arrival order with highest-priority removal.
// ----------------------------------------------------------------------------
// One command item is taken at a time; in_ready is high only while the
// sequencer is idle, and a finished result may still wait in the output
// register while the next item is taken. Jobs live in a single-port-write,
// single-port-read memory with registered read data, and that port sets the
// pace: insert and the one-result cases go from idle straight to the result
// state, remove runs a scan pass, then a shift pass that writes one entry per
// cycle, and listing gives one result per cycle while the output side keeps
// up. Ties in priority remove the earliest job.
module max_priority_job_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mpjq_pkg::CMD_W-1:0]    in_command,
  input  logic [mpjq_pkg::ID_W-1:0]     in_job_id,
  input  logic [mpjq_pkg::PRI_W-1:0]    in_job_priority,
  input  logic [mpjq_pkg::BURST_W-1:0]  in_job_burst,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mpjq_pkg::STAT_W-1:0]   out_status,
  output logic [mpjq_pkg::ID_W-1:0]     out_id,
  output logic [mpjq_pkg::PRI_W-1:0]    out_priority,
  output logic [mpjq_pkg::BURST_W-1:0]  out_burst,
  output logic [mpjq_pkg::OCC_W-1:0]    out_occupancy,
  output logic                          out_last_item
);
  import mpjq_pkg::*;

  mem_req_t mem_req;
  job_t     mem_rd_data;

  mpjq_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_job_id       (in_job_id),
    .in_job_priority (in_job_priority),
    .in_job_burst    (in_job_burst),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_id          (out_id),
    .out_priority    (out_priority),
    .out_burst       (out_burst),
    .out_occupancy   (out_occupancy),
    .out_last_item   (out_last_item),
    .mem_req         (mem_req),
    .mem_rd_data     (mem_rd_data)
  );

  mpjq_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

endmodule

### hdl/mpjq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpjq_checker
// Port-level checks for the job queue, bound to the top level.
// ----------------------------------------------------------------------------
module mpjq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mpjq_pkg::STAT_W-1:0]   out_status,
  input logic [mpjq_pkg::ID_W-1:0]     out_id,
  input logic [mpjq_pkg::PRI_W-1:0]    out_priority,
  input logic [mpjq_pkg::BURST_W-1:0]  out_burst,
  input logic [mpjq_pkg::OCC_W-1:0]    out_occupancy,
  input logic                          out_last_item
);
  import mpjq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_id)
      && $stable(out_priority) && $stable(out_burst) && $stable(out_last_item))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken before the first finished");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_EMPTY) |-> (out_occupancy == '0) && (out_id == '0)
      && (out_priority == '0) && (out_burst == '0) && out_last_item)
    else $error("empty result carries data");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_OVERFLOW) |-> (out_occupancy == OCC_W'(DEPTH))
      && out_last_item)
    else $error("overflow reported below capacity");

  a_list_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_item |-> (out_status == STAT_OK) && (out_occupancy != '0))
    else $error("non-final result with bad status");

endmodule

bind max_priority_job_queue mpjq_checker u_mpjq_checker (.*);

### dv/max_priority_job_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_priority_job_queue_test
// Self-checking bench for the max-priority job queue. A predictor keeps its
// own copy of the held jobs, works out every result of each accepted command
// and a scoreboard compares the block's results with them in order. Directed
// cases cover the empty queue, overflow, ties and field extremes, then random
// traffic sweeps it between empty and full, idling at random in all but one run.
// ----------------------------------------------------------------------------
module max_priority_job_queue_test;
  import mpjq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic [STAT_W-1:0] status;
    job_t              job;
    logic [OCC_W-1:0]  occupancy;
    logic              last;
  } queue_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [CMD_W-1:0]    in_command;
  logic [ID_W-1:0]     in_job_id;
  logic [PRI_W-1:0]    in_job_priority;
  logic [BURST_W-1:0]  in_job_burst;
  logic                out_valid;
  logic                out_ready;
  logic [STAT_W-1:0]   out_status;
  logic [ID_W-1:0]     out_id;
  logic [PRI_W-1:0]    out_priority;
  logic [BURST_W-1:0]  out_burst;
  logic [OCC_W-1:0]    out_occupancy;
  logic                out_last_item;

  job_t          held_jobs[$];
  queue_result_t pending_results[$];
  int            mismatches = 0;
  int            results_seen = 0;
  int            items_sent = 0;
  int            idle_cycles = 0;
  int            cmd_seen[4] = '{0, 0, 0, 0};
  int            overflow_seen = 0;
  int            empty_seen = 0;
  int            peak_occupancy = 0;
  bit            steady_flow = 1'b0;

  max_priority_job_queue u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_job_id       (in_job_id),
    .in_job_priority (in_job_priority),
    .in_job_burst    (in_job_burst),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_id          (out_id),
    .out_priority    (out_priority),
    .out_burst       (out_burst),
    .out_occupancy   (out_occupancy),
    .out_last_item   (out_last_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void expect_result(input logic [STAT_W-1:0] status, input job_t job,
                                        input logic last);
    queue_result_t r;
    r.status    = status;
    r.job       = job;
    r.occupancy = OCC_W'(held_jobs.size());
    r.last      = last;
    pending_results.push_back(r);
    if (status == STAT_OVERFLOW) overflow_seen++;
    if (status == STAT_EMPTY) empty_seen++;
  endfunction

  function automatic void predict_queue_step(input logic [CMD_W-1:0] cmd, input job_t job);
    int              pos;
    logic [PRI_W-1:0] best;
    job_t            taken;
    cmd_seen[cmd]++;
    case (cmd)
      CMD_INSERT: begin
        if (held_jobs.size() >= DEPTH) begin
          expect_result(STAT_OVERFLOW, '0, 1'b1);
        end else begin
          held_jobs.push_back(job);
          expect_result(STAT_OK, '0, 1'b1);
        end
      end
      CMD_REMOVE: begin
        if (held_jobs.size() == 0) begin
          expect_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          pos  = 0;
          best = '0;
          foreach (held_jobs[i]) begin
            if (held_jobs[i].pri > best) begin
              best = held_jobs[i].pri;
              pos  = i;
            end
          end
          taken = held_jobs[pos];
          held_jobs.delete(pos);
          expect_result(STAT_OK, taken, 1'b1);
        end
      end
      CMD_LIST: begin
        if (held_jobs.size() == 0) begin
          expect_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          foreach (held_jobs[i]) expect_result(STAT_OK, held_jobs[i], i == held_jobs.size() - 1);
        end
      end
      default: begin
        expect_result(STAT_OK, '0, 1'b1);
      end
    endcase
    if (held_jobs.size() > peak_occupancy) peak_occupancy = held_jobs.size();
  endfunction

  always @(posedge clk) begin : scoreboard
    queue_result_t want;
    if (rst_n && in_valid && in_ready) begin
      predict_queue_step(in_command, {in_job_id, in_job_priority, in_job_burst});
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: st %0d id %h pri %h burst %h occ %0d last %b",
                   out_status, out_id, out_priority, out_burst, out_occupancy, out_last_item);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_id !== want.job.id ||
            out_priority !== want.job.pri || out_burst !== want.job.burst ||
            out_occupancy !== want.occupancy || out_last_item !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("result %0d expected: st %0d id %h pri %h burst %h occ %0d last %b",
                     results_seen, want.status, want.job.id, want.job.pri, want.job.burst,
                     want.occupancy, want.last);
            $display("result %0d actual:   st %0d id %h pri %h burst %h occ %0d last %b",
                     results_seen, out_status, out_id, out_priority, out_burst,
                     out_occupancy, out_last_item);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", idle_cycles);
      $display("max_priority_job_queue: mismatch");
      $finish;
    end
  end

  initial begin : result_sink
    int hold;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = steady_flow ? 0 : $urandom_range(0, 6);
      @(negedge clk);
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  task automatic send_job(input logic [CMD_W-1:0] cmd, input job_t job);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_job_id       <= job.id;
    in_job_priority <= job.pri;
    in_job_burst    <= job.burst;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_queue();
    send_job(CMD_REMOVE, {8'h00, $urandom});
    send_job(CMD_LIST, {8'h00, $urandom});
    send_job(CMD_UNUSED, {8'h00, $urandom});
  endtask

  task automatic test_fill_and_overflow();
    job_t fill[8] = '{
      {16'h0000, 8'h00, 16'h0000}, {16'hFFFF, 8'hFF, 16'hFFFF},
      {16'h5A5A, 8'h07, 16'hA5A5}, {16'h1234, 8'hFF, 16'h0001},
      {16'hA5A5, 8'h00, 16'h8000}, {16'h8000, 8'h80, 16'h7FFF},
      {16'h0001, 8'h07, 16'hFFFE}, {16'h7FFF, 8'h01, 16'h5555}};
    foreach (fill[i]) send_job(CMD_INSERT, fill[i]);
    send_job(CMD_INSERT, {16'hBEEF, 8'hFF, 16'hCAFE});
    send_job(CMD_LIST, '0);
  endtask

  // ties at 255, 7 and 0: earliest of each must leave first
  task automatic test_priority_order();
    repeat (8) send_job(CMD_REMOVE, {8'h00, $urandom});
  endtask

  task automatic test_all_zero_priority();
    send_job(CMD_INSERT, {16'h00AA, 8'h00, 16'h0011});
    send_job(CMD_INSERT, {16'h00BB, 8'h00, 16'h0022});
    send_job(CMD_REMOVE, '0);
    send_job(CMD_REMOVE, '0);
  endtask

  task automatic test_random_traffic(input int count, input int insert_pct,
                                     input int remove_pct);
    int               pick;
    logic [CMD_W-1:0] cmd;
    job_t             job;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < insert_pct) cmd = CMD_INSERT;
      else if (pick < insert_pct + remove_pct) cmd = CMD_REMOVE;
      else if (pick < 95) cmd = CMD_LIST;
      else cmd = CMD_UNUSED;
      job.id    = ID_W'($urandom);
      job.pri   = PRI_W'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 3));
      job.burst = BURST_W'($urandom);
      send_job(cmd, job);
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_command      = CMD_INSERT;
    in_job_id       = '0;
    in_job_priority = '0;
    in_job_burst    = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_fill_and_overflow();
    test_priority_order();
    test_all_zero_priority();

    test_random_traffic(50, 65, 20);
    test_random_traffic(50, 25, 60);
    drain_results();
    steady_flow = 1'b1;
    test_random_traffic(50, 45, 40);
    steady_flow = 1'b0;
    test_random_traffic(50, 45, 35);

    drain_results();
    repeat (40) @(posedge clk);
    mismatches += pending_results.size();

    $display("covered %0d items: %0d insert, %0d remove, %0d list, %0d unused", items_sent,
             cmd_seen[CMD_INSERT], cmd_seen[CMD_REMOVE], cmd_seen[CMD_LIST],
             cmd_seen[CMD_UNUSED]);
    $display("%0d results checked, %0d overflow, %0d empty, peak occupancy %0d",
             results_seen, overflow_seen, empty_seen, peak_occupancy);
    if (mismatches == 0) begin
      $display("max_priority_job_queue: match");
    end else begin
      $display("max_priority_job_queue: mismatch");
    end
    $finish;
  end

endmodule

### files.f
hdl/mpjq_pkg.sv
hdl/mpjq_store.sv
hdl/mpjq_ctrl.sv
hdl/max_priority_job_queue.sv
hdl/mpjq_checker.sv
dv/max_priority_job_queue_test.sv
